FILE: sv/wprr_pkg.sv
// Package: types, codes and constants of the weighted round-robin scheduler
package wprr_pkg;

    typedef enum logic [2:0] {
        FN_ATTACH  = 3'd0,
        FN_ENQ     = 3'd1,
        FN_DEQ     = 3'd2,
        FN_PICK    = 3'd3,
        FN_CHPRIO  = 3'd4,
        FN_TICK    = 3'd5,
        FN_YIELD   = 3'd6,
        FN_BAD     = 3'd7
    } func_t;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_ALREADY     = 3'd1;
    localparam logic [2:0] ST_NOT_QUEUED  = 3'd2;
    localparam logic [2:0] ST_NOTHING     = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

    localparam logic [1:0] REG_SQM   = 2'd0;
    localparam logic [1:0] REG_SLICE = 2'd1;

    localparam logic [7:0] SLICE_RESET = 8'd10;

    typedef struct packed {
        logic [2:0] func;
        logic [5:0] thread_id;
        logic [6:0] prio_level;
        logic       current_runnable;
        logic       current_is_idle;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] picked_thread;
        logic       picked_valid;
        logic       slice_expired;
    } rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD,
        S_DEC,
        S_PUSH_RD,
        S_PUSH_WR,
        S_REFILL,
        S_BEST,
        S_HEAD_RD,
        S_UNL_RD,
        S_UNL_A,
        S_UNL_B,
        S_UNL_DONE,
        S_DONE
    } state_t;

endpackage

FILE: sv/wprr_ram.sv
// Generic single-port-write RAM with registered read
module wprr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/weighted_priority_round_robin_sched.sv
// Top level: weighted priority round-robin scheduler with level budgets
// Pick uses a one-level-per-cycle scan that can run over all 32 levels twice around a
// budget refill.
// Throughput: one beat in flight; next input accepted the cycle after the result is taken.
// Reset: queued flags and active mask clear, budgets load their level weights,
// single_queue_mode=0, slice_ticks=10; link, level, head, tail and slice memories hold
// undefined data until written.
module weighted_priority_round_robin_sched #(
    parameter int THREADS      = 64,
    parameter int LEVELS       = 32,
    parameter int EXT_PRIO_MIN = 1,
    parameter int EXT_PRIO_MAX = 99
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  wprr_pkg::req_t       in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output wprr_pkg::rsp_t       out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW = $clog2(THREADS);
    localparam int LW = $clog2(LEVELS);
    localparam int SPAN = EXT_PRIO_MAX - EXT_PRIO_MIN;
    localparam logic [LW-1:0] TOP = LW'(LEVELS - 1);

    // per-thread word: level, next, prev, slice
    localparam int EW = LW + 2 * AW + 8;
    localparam int HW = 2 * AW;

    logic          sqm_reg;
    logic [7:0]    slice_reg;

    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[2])
            wprr_pkg::REG_SQM[0]: prdata = {31'd0, sqm_reg};
            default:              prdata = {24'd0, slice_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqm_reg   <= 1'b0;
            slice_reg <= wprr_pkg::SLICE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == wprr_pkg::REG_SQM[0])
            begin
                sqm_reg <= pwdata[0];
            end
            else
            begin
                slice_reg <= pwdata[7:0];
            end
        end
    end

    // thread memory
    logic          tm_we;
    logic [AW-1:0] tm_wa, tm_ra;
    logic [EW-1:0] tm_wd, tm_rd;
    wprr_ram #(.WIDTH(EW), .DEPTH(THREADS)) u_tmem (
        .clk(clk), .we(tm_we), .waddr(tm_wa), .wdata(tm_wd), .raddr(tm_ra), .rdata(tm_rd)
    );
    // level memory: head, tail
    logic          lm_we;
    logic [LW-1:0] lm_wa, lm_ra;
    logic [HW-1:0] lm_wd, lm_rd;
    wprr_ram #(.WIDTH(HW), .DEPTH(LEVELS)) u_lmem (
        .clk(clk), .we(lm_we), .waddr(lm_wa), .wdata(lm_wd), .raddr(lm_ra), .rdata(lm_rd)
    );

    function automatic logic [LW-1:0] ent_lvl(input logic [EW-1:0] e);
        return e[EW-1 -: LW];
    endfunction
    function automatic logic [AW-1:0] ent_nx(input logic [EW-1:0] e);
        return e[2*AW+7 -: AW];
    endfunction
    function automatic logic [AW-1:0] ent_pv(input logic [EW-1:0] e);
        return e[AW+7 -: AW];
    endfunction

    function automatic logic [LW-1:0] scale(input logic [6:0] p);
        logic [31:0] v;
        if (int'(p) < EXT_PRIO_MIN)
        begin
            return '0;
        end
        v = ((32'(p) - 32'(EXT_PRIO_MIN)) * 32'(LEVELS - 1) + 32'(SPAN / 2)) / 32'(SPAN);
        if (v > 32'(LEVELS - 1))
        begin
            v = 32'(LEVELS - 1);
        end
        return v[LW-1:0];
    endfunction

    // scaled level as a constant table over all 7-bit priorities
    logic [LW-1:0] scale_tab [128];
    always_comb
    begin
        for (int i = 0; i < 128; i++)
        begin
            scale_tab[i] = scale(7'(i));
        end
    end

    wprr_pkg::state_t state_reg, state_next;
    wprr_pkg::req_t   req_reg;
    logic [THREADS-1:0] queued_reg, queued_next;
    logic [LEVELS-1:0]  active_reg, active_next;
    logic [3:0]         budget_reg [LEVELS];
    logic [3:0]         budget_next [LEVELS];
    logic               out_valid_reg, out_valid_next;
    wprr_pkg::rsp_t     rsp_reg, rsp_next;

    // working registers
    logic [AW-1:0] t_reg, t_next;          // thread being linked/unlinked
    logic [LW-1:0] l_reg, l_next;          // its level
    logic [EW-1:0] e_reg, e_next;          // its entry
    logic [HW-1:0] ht_reg, ht_next;        // head/tail of l_reg
    logic [AW-1:0] o_reg, o_next;          // neighbor thread
    logic [1:0]    ph_reg, ph_next;        // sub-phase
    logic [2:0]    ret_reg, ret_next;      // continuation after push/unlink
    logic [LW-1:0] nl_reg, nl_next;        // new level for change priority
    logic [LW:0]   scan_reg, scan_next;    // best-level scan
    logic          refilled_reg, refilled_next;

    localparam logic [2:0] RET_DONE = 3'd0;
    localparam logic [2:0] RET_PICK = 3'd1;
    localparam logic [2:0] RET_CHP  = 3'd2;
    localparam logic [2:0] RET_PICKED = 3'd3;

    logic tid_ok;
    assign tid_ok = {26'd0, req_reg.thread_id} < 32'(THREADS);
    logic [AW-1:0] tid;
    assign tid = AW'(req_reg.thread_id);

    assign in_stall  = (state_reg != wprr_pkg::S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    logic [LW-1:0] scan_l;
    assign scan_l = scan_reg[LW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        queued_next   = queued_reg;
        active_next   = active_reg;
        budget_next   = budget_reg;
        out_valid_next = out_valid_reg && out_stall;
        rsp_next      = rsp_reg;
        t_next = t_reg; l_next = l_reg; e_next = e_reg; ht_next = ht_reg;
        o_next = o_reg; ph_next = ph_reg; ret_next = ret_reg; nl_next = nl_reg;
        scan_next = scan_reg; refilled_next = refilled_reg;
        tm_we = 1'b0; tm_wa = t_reg; tm_wd = e_reg; tm_ra = tid;
        lm_we = 1'b0; lm_wa = l_reg; lm_wd = ht_reg; lm_ra = l_reg;
        case (state_reg)
            wprr_pkg::S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    rsp_next = '0;
                    state_next = wprr_pkg::S_RD;
                end
            end
            wprr_pkg::S_RD:
            begin
                // tm read of tid issued here
                tm_ra = tid;
                t_next = tid;
                ret_next = RET_DONE;
                refilled_next = 1'b0;
                state_next = wprr_pkg::S_DEC;
            end
            wprr_pkg::S_DEC:
            begin
                e_next = tm_rd;
                l_next = ent_lvl(tm_rd);
                ph_next = 2'd0;
                state_next = wprr_pkg::S_DONE;
                case (req_reg.func)
                    wprr_pkg::FN_PICK:
                    begin
                        ret_next = RET_PICK;
                        if (tid_ok && !req_reg.current_is_idle && req_reg.current_runnable
                            && !queued_reg[tid])
                        begin
                            state_next = wprr_pkg::S_PUSH_RD;
                        end
                        else
                        begin
                            state_next = wprr_pkg::S_REFILL;
                        end
                    end
                    default:
                    begin
                        if (req_reg.func == wprr_pkg::FN_BAD || !tid_ok)
                        begin
                            rsp_next.status = wprr_pkg::ST_UNSUPPORTED;
                        end
                        else
                        begin
                            case (req_reg.func)
                                wprr_pkg::FN_ATTACH:
                                begin
                                    if (queued_reg[tid])
                                    begin
                                        rsp_next.status = wprr_pkg::ST_ALREADY;
                                    end
                                    else
                                    begin
                                        tm_we = 1'b1; tm_wa = tid;
                                        tm_wd = {sqm_reg ? TOP : scale_tab[req_reg.prio_level],
                                                 tm_rd[2*AW+7:8], slice_reg};
                                    end
                                end
                                wprr_pkg::FN_ENQ:
                                begin
                                    if (queued_reg[tid])
                                    begin
                                        rsp_next.status = wprr_pkg::ST_ALREADY;
                                    end
                                    else
                                    begin
                                        state_next = wprr_pkg::S_PUSH_RD;
                                    end
                                end
                                wprr_pkg::FN_DEQ:
                                begin
                                    if (!queued_reg[tid])
                                    begin
                                        rsp_next.status = wprr_pkg::ST_NOT_QUEUED;
                                    end
                                    else
                                    begin
                                        state_next = wprr_pkg::S_UNL_RD;
                                    end
                                end
                                wprr_pkg::FN_CHPRIO:
                                begin
                                    nl_next = scale_tab[req_reg.prio_level];
                                    if (sqm_reg)
                                    begin
                                        rsp_next.status = wprr_pkg::ST_UNSUPPORTED;
                                    end
                                    else if (scale_tab[req_reg.prio_level] != ent_lvl(tm_rd))
                                    begin
                                        if (queued_reg[tid])
                                        begin
                                            ret_next = RET_CHP;
                                            state_next = wprr_pkg::S_UNL_RD;
                                        end
                                        else
                                        begin
                                            tm_we = 1'b1; tm_wa = tid;
                                            tm_wd = {scale_tab[req_reg.prio_level],
                                                     tm_rd[EW-LW-1:0]};
                                        end
                                    end
                                end
                                wprr_pkg::FN_TICK:
                                begin
                                    tm_we = 1'b1; tm_wa = tid;
                                    if (tm_rd[7:0] == 8'd0)
                                    begin
                                        rsp_next.slice_expired = 1'b1;
                                        tm_wd = tm_rd;
                                    end
                                    else
                                    begin
                                        rsp_next.slice_expired = (tm_rd[7:0] == 8'd1);
                                        tm_wd = {tm_rd[EW-1:8], tm_rd[7:0] - 8'd1};
                                    end
                                end
                                default:
                                begin
                                    tm_we = 1'b1; tm_wa = tid;
                                    tm_wd = {tm_rd[EW-1:8], slice_reg};
                                end
                            endcase
                        end
                    end
                endcase
            end
            // push t_reg (entry e_reg) to tail of l_reg
            wprr_pkg::S_PUSH_RD:
            begin
                if (ph_reg == 2'd0)
                begin
                    lm_ra = l_reg;
                    ph_next = 2'd1;
                end
                else if (ph_reg == 2'd1)
                begin
                    ht_next = lm_rd;
                    o_next = lm_rd[AW-1:0];
                    tm_ra = lm_rd[AW-1:0];
                    ph_next = 2'd2;
                end
                else
                begin
                    state_next = wprr_pkg::S_PUSH_WR;
                    if (active_reg[l_reg])
                    begin
                        tm_we = 1'b1; tm_wa = o_reg;
                        tm_wd = {tm_rd[EW-1 -: LW], t_reg, tm_rd[AW+7:0]};
                        e_next = {e_reg[EW-1 -: LW], t_reg, o_reg, e_reg[7:0]};
                        ht_next = {ht_reg[HW-1 -: AW], t_reg};
                    end
                    else
                    begin
                        e_next = {e_reg[EW-1 -: LW], t_reg, t_reg, e_reg[7:0]};
                        ht_next = {t_reg, t_reg};
                    end
                end
            end
            wprr_pkg::S_PUSH_WR:
            begin
                tm_we = 1'b1; tm_wa = t_reg; tm_wd = e_reg;
                lm_we = 1'b1; lm_wa = l_reg; lm_wd = ht_reg;
                queued_next[t_reg] = 1'b1;
                active_next[l_reg] = 1'b1;
                if (ret_reg == RET_PICK)
                begin
                    state_next = wprr_pkg::S_REFILL;
                end
                else
                begin
                    state_next = wprr_pkg::S_DONE;
                end
            end
            wprr_pkg::S_REFILL:
            begin
                if (budget_reg[0] == 4'd0)
                begin
                    for (int i = 0; i < LEVELS; i++)
                    begin
                        budget_next[i] = 4'(1 << (i >> 3));
                    end
                end
                scan_next = (LW+1)'(LEVELS - 1);
                state_next = wprr_pkg::S_BEST;
            end
            wprr_pkg::S_BEST:
            begin
                if (active_reg[scan_l] && budget_reg[scan_l] != 4'd0)
                begin
                    l_next = scan_l;
                    lm_ra = scan_l;
                    state_next = wprr_pkg::S_HEAD_RD;
                end
                else if (scan_l == '0)
                begin
                    if (refilled_reg)
                    begin
                        rsp_next.status = wprr_pkg::ST_NOTHING;
                        state_next = wprr_pkg::S_DONE;
                    end
                    else
                    begin
                        for (int i = 0; i < LEVELS; i++)
                        begin
                            budget_next[i] = 4'(1 << (i >> 3));
                        end
                        refilled_next = 1'b1;
                        scan_next = (LW+1)'(LEVELS - 1);
                    end
                end
                else
                begin
                    scan_next = scan_reg - (LW+1)'(1);
                end
            end
            wprr_pkg::S_HEAD_RD:
            begin
                t_next = lm_rd[HW-1 -: AW];
                tm_ra = lm_rd[HW-1 -: AW];
                ht_next = lm_rd;
                ret_next = RET_PICKED;
                ph_next = 2'd2;
                state_next = wprr_pkg::S_UNL_RD;
            end
            // unlink t_reg from l_reg
            wprr_pkg::S_UNL_RD:
            begin
                if (ph_reg == 2'd0)
                begin
                    lm_ra = l_reg;
                    ph_next = 2'd1;
                end
                else if (ph_reg == 2'd1)
                begin
                    ht_next = lm_rd;
                    state_next = wprr_pkg::S_UNL_A;
                end
                else
                begin
                    e_next = tm_rd;
                    state_next = wprr_pkg::S_UNL_A;
                end
            end
            wprr_pkg::S_UNL_A:
            begin
                // is_head: ht[HW-1 -: AW]==t, is_tail: ht[AW-1:0]==t
                if (ht_reg[HW-1 -: AW] == t_reg && ht_reg[AW-1:0] == t_reg)
                begin
                    active_next[l_reg] = 1'b0;
                    state_next = wprr_pkg::S_UNL_DONE;
                end
                else
                begin
                    if (ht_reg[HW-1 -: AW] == t_reg)
                    begin
                        ht_next = {ent_nx(e_reg), ht_reg[AW-1:0]};
                        state_next = wprr_pkg::S_UNL_B;
                        tm_ra = ent_nx(e_reg);
                        ph_next = 2'd1;
                    end
                    else
                    begin
                        tm_ra = ent_pv(e_reg);
                        ph_next = 2'd0;
                        state_next = wprr_pkg::S_UNL_B;
                    end
                end
            end
            wprr_pkg::S_UNL_B:
            begin
                if (ph_reg == 2'd0)
                begin
                    // write next of prev
                    tm_we = 1'b1; tm_wa = ent_pv(e_reg);
                    tm_wd = {tm_rd[EW-1 -: LW], ent_nx(e_reg), tm_rd[AW+7:0]};
                    tm_ra = ent_nx(e_reg);
                    ph_next = 2'd1;
                end
                else if (ph_reg == 2'd1)
                begin
                    ph_next = 2'd2;
                    if (ht_reg[AW-1:0] == t_reg)
                    begin
                        ht_next = {ht_reg[HW-1 -: AW], ent_pv(e_reg)};
                    end
                    else
                    begin
                        tm_we = 1'b1; tm_wa = ent_nx(e_reg);
                        tm_wd = {tm_rd[EW-1 -: AW+LW], ent_pv(e_reg), tm_rd[7:0]};
                    end
                end
                else
                begin
                    lm_we = 1'b1; lm_wa = l_reg; lm_wd = ht_reg;
                    state_next = wprr_pkg::S_UNL_DONE;
                end
            end
            wprr_pkg::S_UNL_DONE:
            begin
                queued_next[t_reg] = 1'b0;
                ph_next = 2'd0;
                state_next = wprr_pkg::S_DONE;
                if (ret_reg == RET_CHP)
                begin
                    l_next = nl_reg;
                    e_next = {nl_reg, e_reg[EW-LW-1:0]};
                    ret_next = RET_DONE;
                    state_next = wprr_pkg::S_PUSH_RD;
                end
                else if (ret_reg == RET_PICKED)
                begin
                    if (budget_reg[l_reg] != 4'd0)
                    begin
                        budget_next[l_reg] = budget_reg[l_reg] - 4'd1;
                    end
                    tm_we = 1'b1; tm_wa = t_reg;
                    tm_wd = {e_reg[EW-1:8], slice_reg};
                    rsp_next.picked_thread = 6'(t_reg);
                    rsp_next.picked_valid = 1'b1;
                end
            end
            wprr_pkg::S_DONE:
            begin
                out_valid_next = 1'b1;
                state_next = wprr_pkg::S_IDLE;
            end
            default:
            begin
                state_next = wprr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wprr_pkg::S_IDLE;
            queued_reg    <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                budget_reg[i] <= 4'(1 << (i >> 3));
            end
        end
        else
        begin
            state_reg     <= state_next;
            queued_reg    <= queued_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            budget_reg    <= budget_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg <= in_data;
        end
        rsp_reg <= rsp_next;
        t_reg <= t_next; l_reg <= l_next; e_reg <= e_next; ht_reg <= ht_next;
        o_reg <= o_next; ph_reg <= ph_next; ret_reg <= ret_next; nl_reg <= nl_next;
        scan_reg <= scan_next; refilled_reg <= refilled_next;
    end

`ifndef SYNTHESIS
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == wprr_pkg::S_IDLE)
        else $error("result shown while busy");
    a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == wprr_pkg::S_RD)
        else $error("accepted beat not started");
    a_pick_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.picked_valid) |-> out_data.status == wprr_pkg::ST_OK)
        else $error("picked with bad status");
`endif

endmodule

FILE: tb/sv/tb_weighted_priority_round_robin_sched.sv
// Testbench: weighted priority round-robin scheduler, checked against its own predictor
`timescale 1ns / 100ps

module tb_weighted_priority_round_robin_sched;

    localparam int NTHR = 64;
    localparam int NLVL = 32;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    wprr_pkg::req_t      in_data;
    logic                out_valid;
    logic                out_stall;
    wprr_pkg::rsp_t      out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    weighted_priority_round_robin_sched dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic        sq_mode;
    logic [7:0]  slice_len;
    logic [4:0]  lvl_of_thr [NTHR];
    logic        queued [NTHR];
    logic        attached [NTHR];
    logic [5:0]  nxt [NTHR];
    logic [5:0]  prv [NTHR];
    logic [7:0]  slice_cnt [NTHR];
    logic [5:0]  head [NLVL];
    logic [5:0]  tail [NLVL];
    logic [3:0]  budget [NLVL];
    logic [31:0] active;

    wprr_pkg::req_t pending_reqs [$];
    wprr_pkg::rsp_t expected_rsps [$];
    int   errors;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic in_taken;
    logic hold_req;
    logic hold_seen;
    int   hold_cnt;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [4:0] prio_to_level(input logic [6:0] p);
        int v;
        if (p < 1)
            return 5'd0;
        v = ((p - 1) * 31 + 49) / 98;
        if (v > 31)
            v = 31;
        return v[4:0];
    endfunction

    task automatic refill();
        for (int l = 0; l < NLVL; l++)
            budget[l] = 4'(1 << (l >> 3));
    endtask

    task automatic push_thread(input int t, input int l);
        if (active[l])
        begin
            nxt[tail[l]] = t[5:0];
            prv[t] = tail[l];
        end
        else
        begin
            head[l] = t[5:0];
            prv[t] = t[5:0];
        end
        nxt[t] = t[5:0];
        tail[l] = t[5:0];
        queued[t] = 1'b1;
        active[l] = 1'b1;
    endtask

    task automatic unlink_thread(input int t, input int l);
        logic h;
        logic tl;
        h = (head[l] == t);
        tl = (tail[l] == t);
        if (h && tl)
            active[l] = 1'b0;
        else
        begin
            if (h)
                head[l] = nxt[t];
            else
                nxt[prv[t]] = nxt[t];
            if (tl)
                tail[l] = prv[t];
            else
                prv[nxt[t]] = prv[t];
        end
        queued[t] = 1'b0;
    endtask

    function automatic int best_level();
        for (int l = NLVL - 1; l >= 0; l--)
            if (active[l] && budget[l] > 0)
                return l;
        return -1;
    endfunction

    task automatic predict_sched(input wprr_pkg::req_t r, output wprr_pkg::rsp_t o);
        int t;
        int l;
        int nl;
        t = r.thread_id;
        o = '0;
        o.status = wprr_pkg::ST_OK;
        case (wprr_pkg::func_t'(r.func))
            wprr_pkg::FN_PICK:
            begin
                if (!r.current_is_idle && r.current_runnable && !queued[t])
                    push_thread(t, lvl_of_thr[t]);
                if (budget[0] == 0)
                    refill();
                l = best_level();
                if (l < 0)
                begin
                    refill();
                    l = best_level();
                end
                if (l < 0)
                    o.status = wprr_pkg::ST_NOTHING;
                else
                begin
                    o.picked_thread = head[l];
                    unlink_thread(head[l], l);
                    if (budget[l] > 0)
                        budget[l] = budget[l] - 4'd1;
                    slice_cnt[o.picked_thread] = slice_len;
                    o.picked_valid = 1'b1;
                end
            end
            wprr_pkg::FN_ATTACH:
            begin
                if (queued[t])
                    o.status = wprr_pkg::ST_ALREADY;
                else
                begin
                    lvl_of_thr[t] = sq_mode ? 5'd31 : prio_to_level(r.prio_level);
                    slice_cnt[t] = slice_len;
                    attached[t] = 1'b1;
                end
            end
            wprr_pkg::FN_ENQ:
            begin
                if (queued[t])
                    o.status = wprr_pkg::ST_ALREADY;
                else
                    push_thread(t, lvl_of_thr[t]);
            end
            wprr_pkg::FN_DEQ:
            begin
                if (!queued[t])
                    o.status = wprr_pkg::ST_NOT_QUEUED;
                else
                    unlink_thread(t, lvl_of_thr[t]);
            end
            wprr_pkg::FN_CHPRIO:
            begin
                if (sq_mode)
                    o.status = wprr_pkg::ST_UNSUPPORTED;
                else
                begin
                    nl = prio_to_level(r.prio_level);
                    if (nl != lvl_of_thr[t])
                    begin
                        if (queued[t])
                        begin
                            unlink_thread(t, lvl_of_thr[t]);
                            push_thread(t, nl);
                        end
                        lvl_of_thr[t] = nl[4:0];
                    end
                end
            end
            wprr_pkg::FN_TICK:
            begin
                if (slice_cnt[t] == 0)
                    o.slice_expired = 1'b1;
                else
                begin
                    slice_cnt[t] = slice_cnt[t] - 8'd1;
                    o.slice_expired = (slice_cnt[t] == 0);
                end
            end
            wprr_pkg::FN_YIELD:
                slice_cnt[t] = slice_len;
            default:
                o.status = wprr_pkg::ST_UNSUPPORTED;
        endcase
    endtask

    // build a request; a pick never pushes a thread that is not attached
    function automatic wprr_pkg::req_t make_req(input wprr_pkg::func_t f, input int t,
                                                input int p);
        wprr_pkg::req_t r;
        r.func = f;
        r.thread_id = t[5:0];
        r.prio_level = p[6:0];
        r.current_runnable = 1'($urandom_range(0, 1));
        r.current_is_idle = $urandom_range(0, 3) == 0;
        if (f == wprr_pkg::FN_PICK && !attached[t])
            r.current_runnable = 1'b0;
        return r;
    endfunction

    // accepted-beat flag for the driver
    always @(posedge clk)
        in_taken <= rst_n && in_valid && !in_stall;

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_data <= pending_reqs.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls, plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_req && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_cnt <= 200;
            out_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= $urandom_range(0, 99) < recv_stall_pct;
    end

    // predict on accepted beats, check on delivered beats
    always @(posedge clk)
    begin
        wprr_pkg::rsp_t e;
        if (rst_n && in_valid && !in_stall)
        begin
            predict_sched(in_data, e);
            expected_rsps.push_back(e);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected beat %p", out_data);
                errors++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (out_data.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, out_data.status);
                    errors++;
                end
                if (out_data.picked_thread !== e.picked_thread)
                begin
                    $error("picked_thread exp %0d got %0d", e.picked_thread,
                           out_data.picked_thread);
                    errors++;
                end
                if (out_data.picked_valid !== e.picked_valid)
                begin
                    $error("picked_valid exp %0d got %0d", e.picked_valid,
                           out_data.picked_valid);
                    errors++;
                end
                if (out_data.slice_expired !== e.slice_expired)
                begin
                    $error("slice_expired exp %0d got %0d", e.slice_expired,
                           out_data.slice_expired);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 1'b0} << 1;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == wprr_pkg::REG_SQM)
            sq_mode = val[0];
        else
            slice_len = val[7:0];
    endtask

    // mostly well-formed sequences on a small thread pool, plus noise
    task automatic queue_random(input int n);
        int t;
        int k;
        wprr_pkg::func_t f;
        for (int i = 0; i < n; i++)
        begin
            t = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
            k = $urandom_range(0, 99);
            if (!attached[t] || k < 10)
                f = wprr_pkg::FN_ATTACH;
            else if (k < 35)
                f = wprr_pkg::FN_ENQ;
            else if (k < 45)
                f = wprr_pkg::FN_DEQ;
            else if (k < 70)
                f = wprr_pkg::FN_PICK;
            else if (k < 78)
                f = wprr_pkg::FN_CHPRIO;
            else if (k < 92)
                f = wprr_pkg::FN_TICK;
            else if (k < 97)
                f = wprr_pkg::FN_YIELD;
            else
                f = wprr_pkg::FN_BAD;
            pending_reqs.push_back(make_req(f, t, $urandom_range(0, 127)));
            if (f == wprr_pkg::FN_ATTACH)
                attached[t] = 1'b1;
        end
    endtask

    initial
    begin
        int pct [4];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        in_taken = 1'b0;
        out_stall = 1'b0;
        hold_req = 1'b0;
        hold_seen = 1'b0;
        hold_cnt = 0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sq_mode = 1'b0;
        slice_len = wprr_pkg::SLICE_RESET;
        active = '0;
        for (int i = 0; i < NTHR; i++)
        begin
            queued[i] = 1'b0;
            attached[i] = 1'b0;
        end
        refill();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty pick, extremes, every func, duplicates, zero slice
        write_reg(wprr_pkg::REG_SLICE, 32'd1);
        pending_reqs.push_back(make_req(wprr_pkg::FN_PICK, 0, 0));
        pending_reqs.push_back(make_req(wprr_pkg::FN_ATTACH, 0, 0));
        pending_reqs.push_back(make_req(wprr_pkg::FN_ATTACH, 63, 127));
        pending_reqs.push_back(make_req(wprr_pkg::FN_ATTACH, 5, 99));
        pending_reqs.push_back(make_req(wprr_pkg::FN_ATTACH, 6, 1));
        pending_reqs.push_back(make_req(wprr_pkg::FN_ENQ, 0, 0));
        pending_reqs.push_back(make_req(wprr_pkg::FN_ENQ, 0, 0));
        pending_reqs.push_back(make_req(wprr_pkg::FN_ATTACH, 0, 50));
        pending_reqs.push_back(make_req(wprr_pkg::FN_ENQ, 63, 0));
        pending_reqs.push_back(make_req(wprr_pkg::FN_ENQ, 5, 0));
        pending_reqs.push_back(make_req(wprr_pkg::FN_DEQ, 6, 0));
        pending_reqs.push_back(make_req(wprr_pkg::FN_CHPRIO, 63, 2));
        pending_reqs.push_back(make_req(wprr_pkg::FN_TICK, 5, 0));
        pending_reqs.push_back(make_req(wprr_pkg::FN_TICK, 5, 0));
        pending_reqs.push_back(make_req(wprr_pkg::FN_YIELD, 5, 0));
        pending_reqs.push_back(make_req(wprr_pkg::FN_BAD, 42, 77));
        for (int i = 0; i < 6; i++)
            pending_reqs.push_back(make_req(wprr_pkg::FN_PICK, 63, 0));
        for (int i = 0; i < NTHR; i++)
            attached[i] = attached[i] | (i == 0 || i == 5 || i == 6 || i == 63);
        wait_drained();

        pct = '{0, 76, 0, 10};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(wprr_pkg::REG_SQM, 32'(ph == 2));
            write_reg(wprr_pkg::REG_SLICE, (ph == 1) ? 32'd255 : $urandom_range(1, 6));
            send_idle_pct = pct[ph];
            recv_stall_pct = (ph == 2) ? 76 : pct[ph] == 10 ? 10 : 0;
            if (ph == 0)
                hold_req = 1'b1;
            queue_random(450);
            wait_drained();
        end

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
